@@ rtl/core/arpr_pkg.sv @@
// Shared types, constants and byte-select helpers for the ARP responder.
package arpr_pkg;

  localparam int unsigned ARP_LEN   = 28;
  localparam int unsigned HW_LEN    = 6;
  localparam int unsigned PROTO_LEN = 4;

  // Byte offsets inside an ARP packet.
  localparam logic [4:0] POS_SHA   = 5'd8;
  localparam logic [4:0] POS_SPA   = 5'd14;
  localparam logic [4:0] POS_THA   = 5'd18;
  localparam logic [4:0] POS_TPA   = 5'd24;
  localparam logic [4:0] POS_LAST  = 5'd27;
  localparam logic [4:0] POS_END   = 5'd28;

  // Opcodes.
  localparam logic [7:0] OPER_REQUEST = 8'h01;
  localparam logic [7:0] OPER_REPLY   = 8'h02;

  // Configuration register indexes.
  localparam logic CFG_OWN_IP  = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

  // Requester addresses captured for one reply.
  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ip;
  } reply_t;

  // Front to queue.
  typedef struct packed {
    logic   valid;
    reply_t data;
  } push_t;

  // Queue status seen by front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Fixed header byte: request pattern when checking, reply pattern when sending.
  function automatic logic [7:0] hdr_byte(input logic [2:0] idx, input logic is_reply);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h00;
      3'd1: b = 8'h01;
      3'd2: b = 8'h08;
      3'd3: b = 8'h00;
      3'd4: b = 8'(HW_LEN);
      3'd5: b = 8'(PROTO_LEN);
      3'd6: b = 8'h00;
      3'd7: b = is_reply ? OPER_REPLY : OPER_REQUEST;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Byte of an IPv4 address, most significant first.
  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = ip[31:24];
      2'd1: b = ip[23:16];
      2'd2: b = ip[15:8];
      2'd3: b = ip[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Byte of a hardware address, most significant first.
  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = mac[47:40];
      3'd1: b = mac[39:32];
      3'd2: b = mac[31:24];
      3'd3: b = mac[23:16];
      3'd4: b = mac[15:8];
      3'd5: b = mac[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/arpr_front.sv @@
// Receive-side parser: checks an ARP request byte by byte and queues replies.
module arpr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] rx_byte
  input  logic                s_tlast,   // frame_end
  input  logic [31:0]         own_ip,
  input  arpr_pkg::qstat_t    qstat,
  output arpr_pkg::push_t     push
);
  import arpr_pkg::*;

  logic [4:0]  pos;
  logic        ok;
  logic [47:0] req_mac;
  logic [31:0] req_ip;
  logic        acc;
  logic        byte_ok;
  logic        ok_next;

  // Only the final packet byte can push, so only that one waits on a full queue.
  assign s_tready = !qstat.full || (pos != POS_LAST);
  assign acc      = s_tvalid && s_tready;

  // Check the current byte against the header pattern or the own address.
  always_comb begin
    byte_ok = 1'b1;
    if (pos < POS_SHA) begin
      byte_ok = (s_tdata == hdr_byte(pos[2:0], 1'b0));
    end else if ((pos >= POS_TPA) && (pos < POS_END)) begin
      byte_ok = (s_tdata == ip_byte(own_ip, pos[1:0]));
    end
    ok_next = ok && byte_ok;
  end

  // A reply is queued when the last packet byte arrives and all checks passed.
  always_comb begin
    push.valid    = acc && (pos == POS_LAST) && ok_next;
    push.data.mac = req_mac;
    push.data.ip  = req_ip;
  end

  // Packet position and check flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      ok  <= 1'b1;
    end else if (acc) begin
      if (s_tlast) begin
        pos <= '0;
        ok  <= 1'b1;
      end else begin
        if (pos < POS_END) begin
          pos <= pos + 5'd1;
        end
        ok <= ok_next;
      end
    end
  end

  // Capture the sender addresses as they stream past.
  always_ff @(posedge clk) begin
    if (acc && (pos >= POS_SHA) && (pos < POS_SPA)) begin
      req_mac <= {req_mac[39:0], s_tdata};
    end
    if (acc && (pos >= POS_SPA) && (pos < POS_THA)) begin
      req_ip <= {req_ip[23:0], s_tdata};
    end
  end

endmodule

@@ rtl/core/arpr_queue.sv @@
// Short queue of pending replies between parser and transmitter.
module arpr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  arpr_pkg::push_t    push,
  input  logic               pop,
  output arpr_pkg::reply_t   head,
  output arpr_pkg::qstat_t   qstat
);
  import arpr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  reply_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign head        = mem[rd_ptr];
  assign qstat.full  = (count == CW'(DEPTH));
  assign qstat.empty = (count == '0);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push.valid && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push.valid) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/arpr_back.sv @@
// Transmit side: serializes one queued reply into 28 output words.
module arpr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         own_ip,
  input  logic [47:0]         own_mac,
  input  arpr_pkg::reply_t    head,
  input  arpr_pkg::qstat_t    qstat,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [7:0] tx_byte
  output logic                m_tlast    // tx_last
);
  import arpr_pkg::*;

  logic [4:0] idx;
  logic       load;
  logic [7:0] tx_byte;

  assign load = !qstat.empty && (!m_tvalid || m_tready);
  assign pop  = load && (idx == POS_LAST);

  // Select the reply byte for the current offset.
  always_comb begin
    priority if (idx < POS_SHA) begin
      tx_byte = hdr_byte(idx[2:0], 1'b1);
    end else if (idx < POS_SPA) begin
      tx_byte = mac_byte(own_mac, 3'(idx - POS_SHA));
    end else if (idx < POS_THA) begin
      tx_byte = ip_byte(own_ip, 2'(idx - POS_SPA));
    end else if (idx < POS_TPA) begin
      tx_byte = mac_byte(head.mac, 3'(idx - POS_THA));
    end else begin
      tx_byte = ip_byte(head.ip, idx[1:0]);
    end
  end

  // Output register and byte counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      idx      <= pop ? 5'd0 : idx + 5'd1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= tx_byte;
      m_tlast <= (idx == POS_LAST);
    end
  end

endmodule

@@ rtl/core/arp_request_responder_top.sv @@
// Top level of the ARP request responder: config registers, parser, queue, transmitter.
// Input: one word per cycle; s_tready drops only on the final packet byte while the
// reply queue is full. Output: the 28th request word queues a reply, which the serializer
// counter sends at one word per cycle, 28 words, while m_tready is high.
// Reset (rst, synchronous) empties the queue, clears the parser position and the
// address registers; no clearing pass is needed.
module arp_request_responder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] rx_byte
  input  logic        s_tlast,    // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] tx_byte
  output logic        m_tlast,    // tx_last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);
  import arpr_pkg::*;

  logic [31:0] own_ip;
  logic [47:0] own_mac;
  push_t       push;
  reply_t      head;
  qstat_t      qstat;
  logic        pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_IP:  own_ip  <= cfg_data[31:0];
        CFG_OWN_MAC: own_mac <= cfg_data;
        default:     own_ip  <= own_ip;
      endcase
    end
  end

  arpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .own_ip   (own_ip),
    .qstat    (qstat),
    .push     (push)
  );

  arpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  arpr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .own_ip   (own_ip),
    .own_mac  (own_mac),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // The parser never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst) push.valid |-> !qstat.full)
    else $error("reply pushed into full queue");

  // The transmitter never pops an empty queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("reply popped from empty queue");

  // Popping a reply coincides with loading its last word.
  assert property (@(posedge clk) disable iff (rst) pop |=> (m_tvalid && m_tlast))
    else $error("reply pop without final word");

endmodule

@@ tb/sv/tb_arp_request_responder_top.sv @@
// Self-checking testbench for the ARP request responder: directed, random and back-pressure tests.
module tb_arp_request_responder_top;
  import arpr_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 400;

  // Request header as it must appear on the wire, and the header of every reply.
  localparam logic [63:0] REQ_HDR = {8'h00, 8'h01, 8'h08, 8'h00, 8'(HW_LEN), 8'(PROTO_LEN),
                                     8'h00, OPER_REQUEST};
  localparam logic [63:0] REP_HDR = {8'h00, 8'h01, 8'h08, 8'h00, 8'(HW_LEN), 8'(PROTO_LEN),
                                     8'h00, OPER_REPLY};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
  logic        s_tlast = 1'b0;    // frame_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [7:0] tx_byte
  logic        m_tlast;           // tx_last
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_OWN_IP;
  logic [47:0] cfg_data = '0;

  // Predictor state: packet parser and configured addresses.
  logic [4:0]  arp_pos = '0;
  logic        arp_ok = 1'b1;
  logic [47:0] sender_mac = '0;
  logic [31:0] sender_ip = '0;
  logic [31:0] own_ip = '0;
  logic [47:0] own_mac = '0;

  reply_word_t reply_q[$];
  logic [7:0]  frame_buf[$];
  int          errors = 0;
  int          src_idle_pct = 0;
  int          dst_idle_pct = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  int          stall_cnt = 0;

  arp_request_responder_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Update the parser model with one accepted word and queue any reply it triggers.
  task automatic predict_rx_word(input logic [7:0] b, input logic frame_end);
    int p;
    int sh;
    logic [223:0] reply;
    reply_word_t w;
    p = int'(arp_pos);
    if (p < int'(POS_SHA)) begin
      if (b != REQ_HDR[8 * (7 - p) +: 8]) arp_ok = 1'b0;
    end else if (p < int'(POS_SPA)) begin
      sender_mac = {sender_mac[39:0], b};
    end else if (p < int'(POS_THA)) begin
      sender_ip = {sender_ip[23:0], b};
    end else if (p >= int'(POS_TPA) && p < int'(POS_END)) begin
      sh = 8 * (int'(POS_LAST) - p);
      if (own_ip[sh +: 8] != b) arp_ok = 1'b0;
    end
    if (p < int'(POS_END)) arp_pos = arp_pos + 5'd1;
    if (p == int'(POS_LAST) && arp_ok) begin
      reply = {REP_HDR, own_mac, own_ip, sender_mac, sender_ip};
      for (int k = 0; k < ARP_LEN; k++) begin
        w.data = reply[223 - 8 * k -: 8];
        w.last = (k == ARP_LEN - 1);
        reply_q.insert(reply_q.size(), w);
      end
    end
    if (frame_end) begin
      arp_pos = '0;
      arp_ok  = 1'b1;
    end
  endtask

  // Offer one word, with a random gap first, and wait until it is taken.
  task automatic send_word(input logic [7:0] b, input logic frame_end);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= frame_end;
    do @(posedge clk); while (!s_tready);
    predict_rx_word(b, frame_end);
  endtask

  // Stop offering words and wait until every expected reply word has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OWN_IP) own_ip = val[31:0];
    else own_mac = val;
    @(posedge clk);
  endtask

  // Fill the frame buffer with a well-formed 28-byte request.
  task automatic build_request(input logic [47:0] sha, input logic [31:0] spa,
                               input logic [31:0] tpa);
    logic [223:0] req;
    req = {REQ_HDR, sha, spa, {16'($urandom), $urandom}, tpa};
    frame_buf.delete();
    for (int k = 0; k < ARP_LEN; k++) frame_buf.insert(frame_buf.size(), req[223 - 8 * k -: 8]);
  endtask

  task automatic send_frame(input logic end_mark);
    int n;
    n = frame_buf.size();
    for (int i = 0; i < n; i++) send_word(frame_buf[i], end_mark && (i == n - 1));
  endtask

  task automatic random_config();
    int sel;
    sel = $urandom_range(3);
    cfg_write(CFG_OWN_IP, {16'h0, (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom});
    sel = $urandom_range(3);
    cfg_write(CFG_OWN_MAC, (sel == 0) ? 48'h0 : (sel == 1) ? 48'hFFFF_FFFF_FFFF :
                           {16'($urandom), $urandom});
  endtask

  // One random frame: mostly good requests, the rest broken frames and noise.
  task automatic send_random_frame();
    int kind;
    int n;
    int idx;
    kind = $urandom_range(99);
    build_request({16'($urandom), $urandom}, $urandom, own_ip);
    if (kind < 60) begin
      n = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (n) frame_buf.insert(frame_buf.size(), 8'($urandom));
      send_frame(1'b1);
    end else if (kind < 70) begin
      n = $urandom_range(1, ARP_LEN - 1);
      while (frame_buf.size() > n) void'(frame_buf.pop_back());
      send_frame(1'b1);
    end else if (kind < 80) begin
      idx = $urandom_range(7);
      frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
      send_frame(1'b1);
    end else if (kind < 88) begin
      idx = int'(POS_TPA) + $urandom_range(3);
      frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
      send_frame(1'b1);
    end else begin
      n = $urandom_range(1, 40);
      for (int i = 0; i < n; i++) send_word(8'($urandom), $urandom_range(3) == 0);
    end
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    // Reset configuration answers a request for address zero.
    build_request('1, '1, 32'h0);
    send_frame(1'b1);
    // A frame that ends after a few bytes is dropped.
    build_request({16'($urandom), $urandom}, $urandom, own_ip);
    while (frame_buf.size() > 4) void'(frame_buf.pop_back());
    send_frame(1'b1);
    wait_drained();
  endtask

  task automatic test_random(input int src_pct, input int dst_pct, input int frames);
    wait_drained();
    random_config();
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    repeat (frames) send_random_frame();
  endtask

  // Receiver holds off while requests keep coming, so the reply queue fills up.
  task automatic test_backpressure();
    wait_drained();
    random_config();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    hold_req = HOLD_CYCLES;
    @(posedge clk);
    repeat (3) begin
      build_request({16'($urandom), $urandom}, $urandom, own_ip);
      send_frame(1'b1);
    end
    wait_drained();
  endtask

  // Receiver: random ready, or a long hold when a test asks for one.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Compare every reply word with the oldest expectation.
  always @(posedge clk) begin
    reply_word_t exp_w;
    if (!rst && m_tvalid && m_tready) begin
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply word: expected none, actual data %02h last %0b",
                 $time, m_tdata, m_tlast);
      end else begin
        exp_w = reply_q.pop_front();
        if (m_tdata !== exp_w.data) begin
          errors++;
          $display("%0t: tx_byte mismatch: expected %02h, actual %02h",
                   $time, exp_w.data, m_tdata);
        end
        if (m_tlast !== exp_w.last) begin
          errors++;
          $display("%0t: tx_last mismatch: expected %0b, actual %0b",
                   $time, exp_w.last, m_tlast);
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(12, 64, 1);
    test_random(64, 12, 1);
    test_backpressure();
    wait_drained();
    if (errors == 0 && reply_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (reply_q.size() != 0)
        $display("%0t: %0d reply words expected but never seen", $time, reply_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/arpr_pkg.sv
rtl/core/arpr_front.sv
rtl/core/arpr_queue.sv
rtl/core/arpr_back.sv
rtl/core/arp_request_responder_top.sv
tb/sv/tb_arp_request_responder_top.sv
